/* rtl/morse_led_keyer_assert.svh */
// Assertion macros shared by the keyer's checker.
// No dependencies; include with the bare file name.
`ifndef MORSE_LED_KEYER_ASSERT_SVH
`define MORSE_LED_KEYER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MLK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyer assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define MLK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyer assertion failed");

`endif

/* rtl/mlk_pkg.sv */
// Package for the Morse LED keyer: payload structs, action codes, Morse tables.
// No dependencies.
`default_nettype none

package mlk_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam logic [15:0] UNIT_TICKS_RESET = 16'd100;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [2:0] DOT_UNITS        = 3'd1;
    localparam logic [2:0] DASH_UNITS       = 3'd3;
    localparam logic [2:0] ELEM_GAP_UNITS   = 3'd1;
    localparam logic [2:0] LETTER_END_UNITS = 3'd3;
    localparam logic [2:0] WORD_UNITS       = 3'd7;
    localparam logic [2:0] MESSAGE_UNITS    = 3'd7;
    localparam logic [2:0] MAX_ELEMENTS     = 3'd5;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    // length in bits 7..5, pattern in bits 4..0, bit 0 first, 1 = dash
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'd66,  8'd129, 8'd133, 8'd97,  8'd32,  8'd132, 8'd99,  8'd128, 8'd64,
        8'd142, 8'd101, 8'd130, 8'd67,  8'd65,  8'd103, 8'd134, 8'd139, 8'd98,
        8'd96,  8'd33,  8'd100, 8'd136, 8'd102, 8'd137, 8'd141, 8'd131
    };
    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'd191, 8'd190, 8'd188, 8'd184, 8'd176,
        8'd160, 8'd161, 8'd163, 8'd167, 8'd175
    };

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
    } mlk_req_t;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic accepted;
    } mlk_rsp_t;

    typedef struct packed {
        logic       known;
        logic       is_space;
        logic [4:0] pattern;
        logic [2:0] total;
    } mlk_char_t;

    function automatic logic [2:0] elem_units(input logic [4:0] pattern,
                                              input logic [2:0] pos);
        logic [4:0] shifted;
        shifted = pattern >> pos;
        return shifted[0] ? DASH_UNITS : DOT_UNITS;
    endfunction

endpackage

`default_nettype wire

/* rtl/mlk_char_rom.sv */
// Character lookup: folds case and maps letters, digits and space to Morse elements.
// Depends on mlk_pkg.
`default_nettype none

module mlk_char_rom (
    input  wire logic [7:0]        char_code,
    output mlk_pkg::mlk_char_t     info
);
    import mlk_pkg::*;

    logic [7:0] upper;
    logic [7:0] code;

    always_comb
    begin
        upper = char_code;
        if (char_code inside {[CH_LOWER_A:CH_LOWER_Z]})
        begin
            upper = char_code - CASE_FOLD;
        end
        code = '0;
        info.known = 1'b0;
        info.is_space = 1'b0;
        if (upper == CH_SPACE)
        begin
            info.is_space = 1'b1;
        end
        else if (upper inside {[CH_UPPER_A:CH_UPPER_Z]})
        begin
            code = LETTER_CODES[5'(upper - CH_UPPER_A)];
            info.known = 1'b1;
        end
        else if (upper inside {[CH_ZERO:CH_NINE]})
        begin
            code = DIGIT_CODES[4'(upper - CH_ZERO)];
            info.known = 1'b1;
        end
        info.pattern = code[4:0];
        info.total = code[7:5];
    end

endmodule

`default_nettype wire

/* rtl/morse_led_keyer.sv */
// Top level of the Morse LED keyer: phase machine, unit timer and result register.
// Depends on mlk_pkg and mlk_char_rom.
`default_nettype none

// Morse LED keyer. Each request is a load of one character, a timer tick or an
// end-of-message gap; each produces exactly one response showing the LED level,
// whether a character or gap is still in progress, and whether a load or gap
// request was taken. The phase machine and unit timer update at acceptance and
// the response lands in the output register, visible the next cycle. One
// request per cycle is accepted whenever the response register is empty or
// being drained in the same cycle. Timing of the Morse output is set by
// unit_ticks ticks per unit (0 acts as 1), capped by the range of the
// TICK_COUNT_WIDTH-bit tick counter.
module morse_led_keyer #(
    parameter int TICK_COUNT_WIDTH = mlk_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire mlk_pkg::mlk_req_t req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output mlk_pkg::mlk_rsp_t      rsp_data,
    input  wire logic              unit_ticks_we,
    input  wire logic [15:0]       unit_ticks_data
);
    import mlk_pkg::*;

    localparam int CMP_W = (TICK_COUNT_WIDTH + 1 > 17) ? TICK_COUNT_WIDTH + 1 : 17;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MARK  = 2'd1;
    localparam logic [1:0] PH_GAP   = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;

    logic [15:0]                 unit_ticks_reg;
    logic [4:0]                  pattern_reg, pattern_next;
    logic [2:0]                  total_reg, total_next;
    logic [2:0]                  pos_reg, pos_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [2:0]                  units_reg, units_next;
    logic [TICK_COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    mlk_rsp_t                    rsp_data_reg, rsp_data_next;

    mlk_char_t                   char_info;
    logic                        accept;
    logic                        acc;
    logic [15:0]                 limit;
    logic [CMP_W-1:0]            tick_inc;
    logic                        unit_end;
    logic [2:0]                  pos_inc;

    mlk_char_rom u_char_rom (
        .char_code (req_data.char_code),
        .info      (char_info)
    );

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign limit    = (unit_ticks_reg == '0) ? 16'd1 : unit_ticks_reg;
    assign tick_inc = CMP_W'(tick_reg) + CMP_W'(1);
    assign unit_end = (tick_inc >= CMP_W'(limit)) || (&tick_reg);
    assign pos_inc  = pos_reg + 3'd1;

    always_comb
    begin
        pattern_next = pattern_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        units_next   = units_reg;
        tick_next    = tick_reg;
        acc          = 1'b0;
        if (accept)
        begin
            case (req_data.action)
                ACT_LOAD:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        acc       = 1'b1;
                        tick_next = '0;
                        pos_next  = '0;
                        if (char_info.is_space)
                        begin
                            pattern_next = '0;
                            total_next   = '0;
                            phase_next   = PH_TRAIL;
                            units_next   = WORD_UNITS;
                        end
                        else if (char_info.known)
                        begin
                            pattern_next = char_info.pattern;
                            total_next   = char_info.total;
                            phase_next   = PH_MARK;
                            units_next   = elem_units(char_info.pattern, 3'd0);
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (unit_end)
                        begin
                            tick_next = '0;
                            if (units_reg > 3'd1)
                            begin
                                units_next = units_reg - 3'd1;
                            end
                            else
                            begin
                                case (phase_reg)
                                    PH_MARK:
                                    begin
                                        phase_next = PH_GAP;
                                        units_next = ELEM_GAP_UNITS;
                                    end
                                    PH_GAP:
                                    begin
                                        pos_next = pos_inc;
                                        if (pos_inc < total_reg && pos_inc < MAX_ELEMENTS)
                                        begin
                                            phase_next = PH_MARK;
                                            units_next = elem_units(pattern_reg, pos_inc);
                                        end
                                        else
                                        begin
                                            phase_next = PH_TRAIL;
                                            units_next = LETTER_END_UNITS;
                                        end
                                    end
                                    default:
                                    begin
                                        phase_next = PH_IDLE;
                                        units_next = '0;
                                    end
                                endcase
                            end
                        end
                        else
                        begin
                            tick_next = TICK_COUNT_WIDTH'(tick_inc);
                        end
                    end
                end
                ACT_END:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        acc          = 1'b1;
                        tick_next    = '0;
                        pattern_next = '0;
                        total_next   = '0;
                        pos_next     = '0;
                        phase_next   = PH_TRAIL;
                        units_next   = MESSAGE_UNITS;
                    end
                end
                default:
                begin
                end
            endcase
        end

        rsp_data_next.led_on   = (phase_next == PH_MARK);
        rsp_data_next.busy_res = (phase_next != PH_IDLE);
        rsp_data_next.accepted = acc;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
            pattern_reg    <= '0;
            total_reg      <= '0;
            pos_reg        <= '0;
            phase_reg      <= PH_IDLE;
            units_reg      <= '0;
            tick_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (unit_ticks_we)
            begin
                unit_ticks_reg <= unit_ticks_data;
            end
            pattern_reg   <= pattern_next;
            total_reg     <= total_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            units_reg     <= units_next;
            tick_reg      <= tick_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mlk_checker.sv */
// Port-level checker for the Morse LED keyer, bound to the top level.
// Depends on mlk_pkg and morse_led_keyer_assert.svh.
`default_nettype none

`include "morse_led_keyer_assert.svh"

module mlk_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire mlk_pkg::mlk_req_t req_data,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire mlk_pkg::mlk_rsp_t rsp_data
);
    import mlk_pkg::*;

    logic tick_taken;

    assign tick_taken = req_valid && req_ready && (req_data.action == ACT_TICK);

    `MLK_ASSERT_NEXT(a_rsp_follows_req, req_valid && req_ready, rsp_valid)
    `MLK_ASSERT_NOW(a_no_req_while_full, rsp_valid && !rsp_ready, !req_ready)
    `MLK_ASSERT_NOW(a_led_implies_busy, rsp_valid && rsp_data.led_on, rsp_data.busy_res)
    `MLK_ASSERT_NEXT(a_tick_not_taken, tick_taken, !rsp_data.accepted)
    `MLK_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind morse_led_keyer mlk_checker u_mlk_checker (.*);

`default_nettype wire

/* tb/sv/tb_morse_led_keyer.sv */
// Self-checking testbench for morse_led_keyer: directed table, then random traffic
// under several unit lengths, responses checked against the table or a keyer model.
// Depends on mlk_pkg and the morse_led_keyer RTL.
`default_nettype none

module tb_morse_led_keyer;
    import mlk_pkg::*;

    localparam int TCW = TICK_COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 48;
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef enum logic [1:0] {KEY_IDLE, KEY_MARK, KEY_GAP, KEY_TRAIL} key_phase_t;

    typedef struct packed {
        bit         cfg;
        logic [15:0] unit;
        mlk_req_t   rq;
        bit         typed;
        mlk_rsp_t   want;
    } step_row_t;

    localparam int N_DIRECTED = 22;
    localparam step_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, 16'd0, {ACT_TICK, 8'h00}, 1'b1, 3'b000},
        '{1'b0, 16'd0, {ACT_NOP,  8'hFF}, 1'b1, 3'b000},
        '{1'b0, 16'd0, {ACT_LOAD, 8'h00}, 1'b1, 3'b001},
        '{1'b0, 16'd0, {ACT_LOAD, 8'hFF}, 1'b1, 3'b001},
        '{1'b0, 16'd0, {ACT_LOAD, 8'h2F}, 1'b1, 3'b001},
        '{1'b0, 16'd0, {ACT_LOAD, 8'h3A}, 1'b1, 3'b001},
        '{1'b0, 16'd0, {ACT_LOAD, 8'h40}, 1'b1, 3'b001},
        '{1'b0, 16'd0, {ACT_LOAD, 8'h7B}, 1'b1, 3'b001},
        '{1'b0, 16'd0, {ACT_END,  8'h55}, 1'b1, 3'b011},
        '{1'b0, 16'd0, {ACT_LOAD, 8'h41}, 1'b1, 3'b010},
        '{1'b0, 16'd0, {ACT_END,  8'hAA}, 1'b1, 3'b010},
        '{1'b0, 16'd0, {ACT_NOP,  8'h00}, 1'b1, 3'b010},
        '{1'b0, 16'd0, {ACT_TICK, 8'hFF}, 1'b0, 3'b000},
        '{1'b1, 16'd0, {ACT_TICK, 8'h00}, 1'b0, 3'b000},
        '{1'b0, 16'd0, {ACT_TICK, 8'h00}, 1'b0, 3'b000},
        '{1'b0, 16'd0, {ACT_TICK, 8'h5A}, 1'b0, 3'b000},
        '{1'b0, 16'd0, {ACT_TICK, 8'hA5}, 1'b0, 3'b000},
        '{1'b0, 16'd0, {ACT_TICK, 8'h00}, 1'b0, 3'b000},
        '{1'b0, 16'd0, {ACT_TICK, 8'hFF}, 1'b0, 3'b000},
        '{1'b0, 16'd0, {ACT_TICK, 8'h00}, 1'b0, 3'b000},
        '{1'b0, 16'd0, {ACT_TICK, 8'h00}, 1'b1, 3'b000},
        '{1'b0, 16'd0, {ACT_LOAD, 8'h20}, 1'b1, 3'b011}
    };

    localparam int N_PHASES = 8;
    localparam logic [15:0] PHASE_UNITS [N_PHASES] = '{
        16'd1, 16'd2, 16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd4, 16'd2
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    mlk_req_t    req_data = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    mlk_rsp_t    rsp_data;
    logic        unit_ticks_we = 1'b0;
    logic [15:0] unit_ticks_data = '0;

    logic [15:0]    unit_len;
    logic [4:0]     dash_map;
    logic [2:0]     elem_count;
    logic [2:0]     elem_at;
    key_phase_t     key_phase;
    logic [2:0]     units_left;
    logic [TCW-1:0] tick_cnt;

    mlk_rsp_t led_state_q [$];
    int  err_cnt = 0;
    int  sent_cnt = 0;
    int  checked_cnt = 0;
    int  taken_cnt = 0;
    int  cycle_cnt = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    morse_led_keyer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req_data        (req_data),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp_data        (rsp_data),
        .unit_ticks_we   (unit_ticks_we),
        .unit_ticks_data (unit_ticks_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [2:0] mark_len();
        return (((dash_map >> elem_at) & 5'd1) != 5'd0) ? DASH_UNITS : DOT_UNITS;
    endfunction

    task automatic close_phase();
        case (key_phase)
            KEY_MARK:
            begin
                key_phase = KEY_GAP;
                units_left = ELEM_GAP_UNITS;
            end
            KEY_GAP:
            begin
                elem_at = elem_at + 3'd1;
                if (elem_at < elem_count && elem_at < MAX_ELEMENTS)
                begin
                    key_phase = KEY_MARK;
                    units_left = mark_len();
                end
                else
                begin
                    key_phase = KEY_TRAIL;
                    units_left = LETTER_END_UNITS;
                end
            end
            default:
            begin
                key_phase = KEY_IDLE;
                units_left = '0;
            end
        endcase
    endtask

    task automatic count_tick();
        longint unsigned lim;
        longint unsigned nxt;
        if (key_phase != KEY_IDLE)
        begin
            lim = (unit_len == 16'd0) ? 1 : unit_len;
            nxt = tick_cnt + 1;
            if (nxt >= lim || tick_cnt == '1)
            begin
                tick_cnt = '0;
                if (units_left > 3'd1)
                    units_left = units_left - 3'd1;
                else
                    close_phase();
            end
            else
            begin
                tick_cnt = nxt[TCW-1:0];
            end
        end
    endtask

    task automatic load_char(input logic [7:0] ch);
        logic [7:0] c;
        logic [7:0] code;
        bit         known;
        c = ch;
        known = 1'b1;
        code = '0;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            c = c - CASE_FOLD;
        tick_cnt = '0;
        elem_at = '0;
        if (c == CH_SPACE)
        begin
            dash_map = '0;
            elem_count = '0;
            key_phase = KEY_TRAIL;
            units_left = WORD_UNITS;
        end
        else
        begin
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                code = LETTER_CODES[5'(c - CH_UPPER_A)];
            else if (c >= CH_ZERO && c <= CH_NINE)
                code = DIGIT_CODES[4'(c - CH_ZERO)];
            else
                known = 1'b0;
            if (known)
            begin
                dash_map = code[4:0];
                elem_count = code[7:5];
                key_phase = KEY_MARK;
                units_left = mark_len();
            end
        end
    endtask

    task automatic advance_keyer(input mlk_req_t rq, output mlk_rsp_t rs);
        logic taken;
        taken = 1'b0;
        case (rq.action)
            ACT_LOAD:
            begin
                if (key_phase == KEY_IDLE)
                begin
                    taken = 1'b1;
                    load_char(rq.char_code);
                end
            end
            ACT_TICK:
                count_tick();
            ACT_END:
            begin
                if (key_phase == KEY_IDLE)
                begin
                    taken = 1'b1;
                    tick_cnt = '0;
                    dash_map = '0;
                    elem_count = '0;
                    elem_at = '0;
                    key_phase = KEY_TRAIL;
                    units_left = MESSAGE_UNITS;
                end
            end
            default: ;
        endcase
        rs.led_on = (key_phase == KEY_MARK);
        rs.busy_res = (key_phase != KEY_IDLE);
        rs.accepted = taken;
    endtask

    task automatic pick_request(output mlk_req_t rq);
        int roll;
        int kind;
        roll = $urandom_range(0, 99);
        rq.char_code = 8'($urandom_range(0, 255));
        rq.action = 2'($urandom_range(0, 3));
        if (key_phase != KEY_IDLE)
        begin
            if (roll < 90)
                rq.action = ACT_TICK;
        end
        else if (roll < 85)
        begin
            kind = $urandom_range(0, 9);
            rq.action = ACT_LOAD;
            if (kind <= 4)
                rq.char_code = 8'($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A)
                               + 8'($urandom_range(0, 25));
            else if (kind <= 6)
                rq.char_code = CH_ZERO + 8'($urandom_range(0, 9));
            else if (kind == 7)
                rq.char_code = CH_SPACE;
            else if (kind == 8)
                rq.action = ACT_END;
            else
                rq.char_code = CH_UPPER_A + 8'($urandom_range(0, 25));
        end
    endtask

    task automatic push_request(input mlk_req_t rq, input bit typed, input mlk_rsp_t want);
        mlk_rsp_t got;
        while (!quiet && $urandom_range(0, 99) < 6)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data <= rq;
        do @(posedge clk); while (!req_ready);
        advance_keyer(rq, got);
        led_state_q.push_back(typed ? want : got);
        sent_cnt++;
        if (got.accepted)
            taken_cnt++;
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (led_state_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_unit_len(input logic [15:0] v);
        drain();
        @(negedge clk);
        unit_ticks_we <= 1'b1;
        unit_ticks_data <= v;
        @(posedge clk);
        unit_len = v;
        @(negedge clk);
        unit_ticks_we <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= quiet || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    always @(posedge clk)
    begin
        mlk_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (led_state_q.size() == 0)
            begin
                $error("unexpected response %b with nothing outstanding", rsp_data);
                err_cnt++;
            end
            else
            begin
                want = led_state_q.pop_front();
                checked_cnt++;
                if (rsp_data.led_on !== want.led_on)
                begin
                    $error("led_on: expected %0d, actual %0d", want.led_on, rsp_data.led_on);
                    err_cnt++;
                end
                if (rsp_data.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, actual %0d",
                           want.busy_res, rsp_data.busy_res);
                    err_cnt++;
                end
                if (rsp_data.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, actual %0d",
                           want.accepted, rsp_data.accepted);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        mlk_req_t rq;
        int       n;
        unit_len = UNIT_TICKS_RESET;
        dash_map = '0;
        elem_count = '0;
        elem_at = '0;
        key_phase = KEY_IDLE;
        units_left = '0;
        tick_cnt = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (DIRECTED[r].cfg)
                set_unit_len(DIRECTED[r].unit);
            else
                push_request(DIRECTED[r].rq, DIRECTED[r].typed, DIRECTED[r].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_unit_len(PHASE_UNITS[p]);
            quiet = (p == 2);
            n = (PHASE_UNITS[p] == 16'hFFFF) ? 40 : 115;
            for (int i = 0; i < n; i++)
            begin
                if (p == 3 && i == 30)
                    hold_req = 1'b1;
                if (p == 5 && i == 50)
                    drain();
                pick_request(rq);
                push_request(rq, 1'b0, '0);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (led_state_q.size() != 0)
        begin
            $error("%0d responses never arrived", led_state_q.size());
            err_cnt++;
        end

        $display("%0d requests driven, %0d responses compared, %0d loads/gaps taken",
                 sent_cnt, checked_cnt, taken_cnt);
        $display("unit lengths swept from 0 to 65535, with long output back-pressure");
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/mlk_pkg.sv
rtl/mlk_char_rom.sv
rtl/morse_led_keyer.sv
rtl/mlk_checker.sv
tb/sv/tb_morse_led_keyer.sv
